### src/sobm_pkg.sv
`default_nettype none

package sobm_pkg;

  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int MAG_W      = 11;
  localparam int RAD_W      = 2 * MAG_W;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int ROOT_STEPS = MAG_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_ROOT,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;     // take pixel, start line store read, step position
    logic grad;       // window + gradients, line store write back
    logic square;     // sum of squares, clear root unit
    logic root_step;  // one result bit of the square root
    logic load_out;   // move finished result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic produce;    // current item yields a result
    logic out_busy;   // output register held by downstream stall
  } dp_status_t;

endpackage

`default_nettype wire

### src/sobm_ram.sv
`default_nettype none

module sobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/sobm_ctrl.sv
`default_nettype none

module sobm_ctrl
  import sobm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  ctrl_state_e            state_q, state_d;
  logic [ROOT_CNT_W-1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.grad = 1'b1;
        state_d    = status_i.produce ? ST_SQUARE : ST_IDLE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        cnt_d        = '0;
        state_d      = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/sobm_datapath.sv
`default_nettype none

module sobm_datapath
  import sobm_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,
  input  wire logic [PIX_W-1:0]         pixel_value_i,
  input  wire logic                     out_stall_i,
  input  wire dp_cmd_t                  cmd_i,
  output dp_status_t                    status_o,
  output logic                          out_valid_o,
  output logic [MAG_W-1:0]              magnitude_o,
  output logic signed [GRAD_W-1:0]      grad_first_o,
  output logic signed [GRAD_W-1:0]      grad_second_o,
  output logic                          row_end_o,
  output logic                          frame_end_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(MAX_HEIGHT);
  localparam int WLAST_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH - 1
                                                          : FRAME_WIDTH_RST - 1;
  localparam int HLAST_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT - 1
                                                            : FRAME_HEIGHT_RST - 1;

  // frame geometry, kept as last column / last row index
  logic [AW-1:0] wlast_q, wlast_d;
  logic [RB-1:0] hlast_q, hlast_d;
  logic [AW-1:0] col_q, col_d;
  logic [RB-1:0] row_q, row_d;
  logic [31:0]   cfg_w, cfg_h;

  always_comb begin
    cfg_w   = 32'(cfg_data_i[FW_W-1:0]);
    cfg_h   = 32'(cfg_data_i[FH_W-1:0]);
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (cfg_w < 32'd3) begin
      wlast_d = AW'(2);
    end else if (cfg_w > 32'(MAX_WIDTH)) begin
      wlast_d = AW'(MAX_WIDTH - 1);
    end else begin
      wlast_d = AW'(cfg_w - 32'd1);
    end
    if (cfg_h < 32'd3) begin
      hlast_d = RB'(2);
    end else if (cfg_h > 32'(MAX_HEIGHT)) begin
      hlast_d = RB'(MAX_HEIGHT - 1);
    end else begin
      hlast_d = RB'(cfg_h - 32'd1);
    end
  end

  // raster position of the next pixel
  logic at_row_end, at_frame_end;

  assign at_row_end   = (col_q == wlast_q);
  assign at_frame_end = at_row_end && (row_q == hlast_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.accept) begin
      if (at_row_end) begin
        col_d = '0;
        row_d = (row_q == hlast_q) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= AW'(WLAST_RST);
      hlast_q <= RB'(HLAST_RST);
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          wlast_q <= wlast_d;
          col_q   <= '0;
          row_q   <= '0;
        end
        REG_FRAME_HEIGHT: begin
          hlast_q <= hlast_d;
          col_q   <= '0;
          row_q   <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // item capture
  logic [PIX_W-1:0] pix_q;
  logic [AW-1:0]    addr_q;
  logic             produce_q, row_end_q, frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      produce_q <= 1'b0;
    end else if (cmd_i.accept) begin
      produce_q <= (col_q >= AW'(2)) && (row_q >= RB'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q       <= pixel_value_i;
      addr_q      <= col_q;
      row_end_q   <= at_row_end;
      frame_end_q <= at_frame_end;
    end
  end

  // line stores: read at accept, written back in the cycle after
  logic [PIX_W-1:0] top, mid;

  sobm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_older (
    .clk_i   (clk_i),
    .we_i    (cmd_i.grad),
    .waddr_i (addr_q),
    .wdata_i (mid),
    .raddr_i (col_q),
    .rdata_o (top)
  );

  sobm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_newer (
    .clk_i   (clk_i),
    .we_i    (cmd_i.grad),
    .waddr_i (addr_q),
    .wdata_i (pix_q),
    .raddr_i (col_q),
    .rdata_o (mid)
  );

  // window: [0..2] two columns back, [3..5] one column back (top, mid, bot)
  logic [PIX_W-1:0] win_q [6];

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= pix_q;
    end
  end

  // gradients; wraparound in GRAD_W bits is exact since results fit
  logic signed [GRAD_W-1:0] t0, t1, t2, m0, m2, b0, b1, b2;
  logic signed [GRAD_W-1:0] g1, g2, g1_q, g2_q;

  always_comb begin
    t0 = $signed(GRAD_W'(win_q[0]));
    t1 = $signed(GRAD_W'(win_q[3]));
    t2 = $signed(GRAD_W'(top));
    m0 = $signed(GRAD_W'(win_q[1]));
    m2 = $signed(GRAD_W'(mid));
    b0 = $signed(GRAD_W'(win_q[2]));
    b1 = $signed(GRAD_W'(win_q[5]));
    b2 = $signed(GRAD_W'(pix_q));
    g1 = (t0 + (t1 <<< 1) + t2) - (b0 + (b1 <<< 1) + b2);
    g2 = (t0 - t2) + ((m0 - m2) <<< 1) + (b0 - b2);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      g1_q <= g1;
      g2_q <= g2;
    end
  end

  // sum of squares, then restoring square root, one result bit per step
  logic signed [RAD_W-1:0] sq1, sq2;
  logic [RAD_W-1:0]        rad_q;
  logic [MAG_W+1:0]        rem_q;
  logic [MAG_W-1:0]        root_q;
  logic [MAG_W+3:0]        rem_next, trial;

  assign sq1      = RAD_W'(g1_q) * RAD_W'(g1_q);
  assign sq2      = RAD_W'(g2_q) * RAD_W'(g2_q);
  assign rem_next = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial    = (MAG_W + 4)'({root_q, 2'b01});

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      rad_q  <= RAD_W'(sq1 + sq2);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_next >= trial) begin
        rem_q  <= (MAG_W + 2)'(rem_next - trial);
        root_q <= {root_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_next[MAG_W+1:0];
        root_q <= {root_q[MAG_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      magnitude_o   <= root_q;
      grad_first_o  <= g1_q;
      grad_second_o <= g2_q;
      row_end_o     <= row_end_q;
      frame_end_o   <= frame_end_q;
    end
  end

  assign status_o.produce  = produce_q;
  assign status_o.out_busy = out_valid_o && out_stall_i;

endmodule

`default_nettype wire

### src/sobel_edge_magnitude.sv
// Sobel 3x3 gradients and magnitude over a raster pixel stream.
// One pixel at a time: in_stall_o stays high from accept until the line stores
// are written back (border pixel) or the result is loaded after the bit-serial
// square root (interior pixel); next item is taken while a result waits.
// Reset (rst_ni low, async): idle, position row 0 column 0, 640 x 480 frame,
// output empty; line stores are not cleared.
`default_nettype none

module sobel_edge_magnitude
  import sobm_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  // pixel items in
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [PIX_W-1:0]       pixel_value_i,
  // result items out
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [MAG_W-1:0]            magnitude_o,
  output logic signed [GRAD_W-1:0]    grad_first_o,
  output logic signed [GRAD_W-1:0]    grad_second_o,
  output logic                        row_end_o,
  output logic                        frame_end_o
);

  // Controller sequence per item:
  //   IDLE   - take the pixel, read both line stores at the current column
  //   READ   - form the 3x3 window, compute both gradients, write the column
  //            back (older <= newer, newer <= pixel), shift the window
  //   SQUARE - gx^2 + gy^2 into the root unit (border pixels skip ahead to IDLE)
  //   ROOT   - 11 restoring steps, one magnitude bit each
  //   DONE   - park result in the output register once it is free
  dp_cmd_t    cmd;
  dp_status_t status;

  sobm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath holds geometry registers, raster counters, both line stores,
  // the window, the gradient and root registers and the output register.
  // A write to either frame register restarts the frame at row 0 column 0.
  sobm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_value_i (pixel_value_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .magnitude_o   (magnitude_o),
    .grad_first_o  (grad_first_o),
    .grad_second_o (grad_second_o),
    .row_end_o     (row_end_o),
    .frame_end_o   (frame_end_o)
  );

`ifndef SYNTH
  // commands are mutually exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.grad, cmd.square, cmd.root_step, cmd.load_out}))
    else $error("more than one datapath command");

  // an item is taken into the datapath only on a real handshake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> (in_valid_i && !in_stall_o))
    else $error("accept without handshake");

  // a held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd.load_out)
    else $error("output register overwritten while stalled");

  // a loaded result shows up as valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not valid");
`endif

endmodule

`default_nettype wire

### tb/sv/sobel_edge_magnitude_test.sv
module sobel_edge_magnitude_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sobm_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_PIXELS = 600;
  // settle time after the queues drain, so border pixels finish and the block idles
  localparam int SETTLE_CYCLES = 32;
  // bound on waiting for results once the last pixel went in
  localparam int DRAIN_LIMIT   = 5000;
  localparam longint CYCLE_LIMIT = 2_000_000;

  localparam logic [PIX_W-1:0] PIX_MAX = '1;
  localparam logic [PIX_W-1:0] PIX_MIN = '0;

  // indexes past the register list; writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum int {
    STYLE_NOISE,   // uniform 0..255
    STYLE_BINARY,  // 0 or 255 only, drives gradients to their extremes
    STYLE_MIXED    // extremes mixed with noise
  } pix_style_e;

  typedef struct packed {
    logic [MAG_W-1:0]          mag;
    logic signed [GRAD_W-1:0]  g_first;
    logic signed [GRAD_W-1:0]  g_second;
    logic                      row_last;
    logic                      frame_last;
  } sobel_result_t;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                     clk_i;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i   = '0;
  logic [CFG_W-1:0]         cfg_data_i    = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic [PIX_W-1:0]         pixel_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic [MAG_W-1:0]         magnitude_o;
  logic signed [GRAD_W-1:0] grad_first_o;
  logic signed [GRAD_W-1:0] grad_second_o;
  logic                     row_end_o;
  logic                     frame_end_o;

  sobel_edge_magnitude #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_value_i(pixel_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .magnitude_o  (magnitude_o),
    .grad_first_o (grad_first_o),
    .grad_second_o(grad_second_o),
    .row_end_o    (row_end_o),
    .frame_end_o  (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(HALF_PERIOD) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] pixel_q[$];        // pixels waiting for the driver
  sobel_result_t    grad_expect_q[$];  // predicted results, oldest first

  bit  pix_taken;       // pixel accepted at the last rising edge
  bit  send_idle_on;    // sender inserts gaps
  bit  recv_idle_on;    // receiver stalls
  int  send_gap;
  int  stall_left;

  int  err_cnt;
  int  pix_cnt;
  int  result_cnt;
  int  frame_cnt;
  int  cfg_cnt;
  longint unsigned cycle_cnt = 0;

  // predictor state: two previous rows, last two columns, raster position
  logic [PIX_W-1:0] line_two_up [MAX_W];
  logic [PIX_W-1:0] line_one_up [MAX_W];
  logic [PIX_W-1:0] win_px [6];
  int               col_at;
  int               row_at;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int active_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_W) return MAX_W;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    if (height_reg < 3) return 3;
    if (height_reg > MAX_H) return MAX_H;
    return int'(height_reg);
  endfunction

  // bit-by-bit floor square root, result fits MAG_W bits
  function automatic int floor_root(int v);
    int r;
    r = 0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      if ((r + (1 << b)) * (r + (1 << b)) <= v) r += (1 << b);
    end
    return r;
  endfunction

  // any write to a known register restarts the frame; stores keep contents
  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    if (idx == REG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
    else if (idx == REG_FRAME_HEIGHT) height_reg = val[FH_W-1:0];
    else return;
    col_at = 0;
    row_at = 0;
  endfunction

  function automatic void sobel_predict(logic [PIX_W-1:0] pix);
    int w, h, t0, t1, t2, m0, m2, b0, b1, b2, gv, gh;
    logic [PIX_W-1:0] top, mid;
    sobel_result_t res;
    w = active_width();
    h = active_height();
    top = line_two_up[col_at];
    mid = line_one_up[col_at];
    line_two_up[col_at] = mid;
    line_one_up[col_at] = pix;
    // only positions whose whole 3x3 window is inside the frame give a result
    if (col_at >= 2 && row_at >= 2) begin
      t0 = win_px[0]; t1 = win_px[3]; t2 = top;
      m0 = win_px[1];                 m2 = mid;
      b0 = win_px[2]; b1 = win_px[5]; b2 = pix;
      gv = (t0 + 2 * t1 + t2) - (b0 + 2 * b1 + b2);
      gh = (t0 - t2) + 2 * (m0 - m2) + (b0 - b2);
      res.mag        = MAG_W'(floor_root(gv * gv + gh * gh));
      res.g_first    = GRAD_W'(gv);
      res.g_second   = GRAD_W'(gh);
      res.row_last   = (col_at + 1 >= w);
      res.frame_last = (col_at + 1 >= w) && (row_at + 1 >= h);
      grad_expect_q.push_back(res);
    end
    win_px[0] = win_px[3];
    win_px[1] = win_px[4];
    win_px[2] = win_px[5];
    win_px[3] = top;
    win_px[4] = mid;
    win_px[5] = pix;
    col_at++;
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
      if (row_at >= h) row_at = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] gen_pixel(pix_style_e s);
    case (s)
      STYLE_NOISE:  return PIX_W'($urandom_range(0, 255));
      STYLE_BINARY: return $urandom_range(0, 1) ? PIX_MAX : PIX_MIN;
      default: begin
        case ($urandom_range(0, 2))
          0:       return PIX_MIN;
          1:       return PIX_MAX;
          default: return PIX_W'($urandom_range(0, 255));
        endcase
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // block must be idle here; model follows the port at the same edge
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    apply_cfg(idx, val);
    cfg_cnt++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // all pixels in, all results out, then let border pixels finish
  task automatic wait_idle();
    int n;
    do @(negedge clk_i); while (pixel_q.size() != 0 || in_valid_i);
    n = 0;
    while (grad_expect_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk_i);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: inputs move on the falling edge, payload held while stalled
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || pix_taken) begin
      if (send_gap > 0 || pixel_q.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i    <= 1'b1;
        pixel_value_i <= pixel_q.pop_front();
        send_gap = send_idle_on ? idle_len() : 0;
      end
    end
  end

  // accepted pixels feed the predictor
  always @(posedge clk_i) begin
    pix_taken = rst_ni && in_valid_i && !in_stall_o;
    if (pix_taken) begin
      sobel_predict(pixel_value_i);
      pix_cnt++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall, check every accepted result
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = recv_idle_on ? idle_len() : 0;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    sobel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_cnt++;
      if (frame_end_o) frame_cnt++;
      if (grad_expect_q.size() == 0) begin
        $display("%0t: result with none expected, mag %0d gx1 %0d gx2 %0d",
                 $time, magnitude_o, grad_first_o, grad_second_o);
        err_cnt++;
      end else begin
        want = grad_expect_q.pop_front();
        check_field("magnitude", want.mag, magnitude_o);
        check_field("grad_first", want.g_first, grad_first_o);
        check_field("grad_second", want.g_second, grad_second_o);
        check_field("row_end", want.row_last, row_end_o);
        check_field("frame_end", want.frame_last, frame_end_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still pending",
             cycle_cnt, grad_expect_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int w, h, fsz, n, rnd, pushed;
    logic [CFG_W-1:0] val;
    pix_style_e style;

    // predictor reset state: position and frame size as in the block after reset
    foreach (line_two_up[i]) begin
      line_two_up[i] = PIX_MIN;
      line_one_up[i] = PIX_MIN;
    end
    foreach (win_px[i]) win_px[i] = PIX_MIN;
    col_at       = 0;
    row_at       = 0;
    width_reg    = FW_W'(FRAME_WIDTH_RST);
    height_reg   = FH_W'(FRAME_HEIGHT_RST);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // -- directed ------------------------------------------------------------
    // 3 x 4 frame: bright top row then bright bottom row, so the vertical
    // gradient hits both of its limits
    cfg_write(REG_FRAME_WIDTH, CFG_W'(3));
    cfg_write(REG_FRAME_HEIGHT, CFG_W'(4));
    for (int i = 0; i < 12; i++) pixel_q.push_back((i < 3 || i >= 9) ? PIX_MAX : PIX_MIN);
    wait_idle();

    // zero in both registers saturates to 3 x 3; bright right column gives
    // the horizontal gradient its low limit
    cfg_write(REG_FRAME_WIDTH, CFG_W'(0));
    cfg_write(REG_FRAME_HEIGHT, CFG_W'(0));
    for (int i = 0; i < 6; i++) pixel_q.push_back((i % 3 == 2) ? PIX_MAX : PIX_MIN);
    wait_idle();
    // writes past the register list must not restart the frame
    cfg_write(REG_SPARE_LO, '1);
    cfg_write(REG_SPARE_HI, '1);
    for (int i = 0; i < 3; i++) pixel_q.push_back((i == 2) ? PIX_MAX : PIX_MIN);
    wait_idle();

    // -- size extremes ----------------------------------------------------------
    // all-ones width is masked to 2047 and saturates to the full line; a short
    // run in the first row must give no result
    cfg_write(REG_FRAME_WIDTH, '1);
    cfg_write(REG_FRAME_HEIGHT, CFG_W'(3));
    for (int i = 0; i < 64; i++) pixel_q.push_back(gen_pixel(STYLE_MIXED));
    wait_idle();
    // tallest frame: partial only, frame end must stay low
    cfg_write(REG_FRAME_WIDTH, CFG_W'(3));
    cfg_write(REG_FRAME_HEIGHT, '1);
    for (int i = 0; i < 3 * 40; i++) pixel_q.push_back(gen_pixel(STYLE_NOISE));
    wait_idle();

    // -- random phases ----------------------------------------------------------
    // each phase: maybe reprogram, push whole frames or a partial run, drain
    pushed = 0;
    while (pushed < RANDOM_PIXELS) begin
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);

      rnd = $urandom_range(0, 99);
      if (rnd >= 15 && rnd < 60 || rnd >= 75) begin
        case ($urandom_range(0, 9))
          0:       val = CFG_W'($urandom_range(0, 2));
          1:       val = CFG_W'($urandom_range(11, 40));
          2:       val = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
          default: val = CFG_W'($urandom_range(3, 10));
        endcase
        cfg_write(REG_FRAME_WIDTH, val);
      end
      if (rnd >= 45) begin
        case ($urandom_range(0, 9))
          0:       val = CFG_W'($urandom_range(0, 2));
          1:       val = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
          default: val = CFG_W'($urandom_range(3, 6));
        endcase
        cfg_write(REG_FRAME_HEIGHT, val);
      end
      if ($urandom_range(0, 9) == 0) begin
        cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
      end

      w   = active_width();
      h   = active_height();
      fsz = w * h;
      if ($urandom_range(0, 99) < 70 && fsz <= 300) n = fsz * $urandom_range(1, 2);
      else n = $urandom_range(1, (fsz < 300) ? fsz : 300);
      style = pix_style_e'($urandom_range(0, 2));
      for (int i = 0; i < n; i++) pixel_q.push_back(gen_pixel(style));
      pushed += n;
      wait_idle();
    end

    // -- wrap up ----------------------------------------------------------------
    wait_idle();
    if (grad_expect_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, grad_expect_q.size());
      err_cnt += grad_expect_q.size();
    end
    $display("Run covered %0d pixels, %0d results, %0d frame ends, %0d register writes",
             pix_cnt, result_cnt, frame_cnt, cfg_cnt);
    $display("Sizes from the 3 x 3 minimum up to saturated width and height, partial frames too");
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
src/sobm_pkg.sv
src/sobm_ram.sv
src/sobm_ctrl.sv
src/sobm_datapath.sv
src/sobel_edge_magnitude.sv
tb/sv/sobel_edge_magnitude_test.sv
